// ===== rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants for the vector normaliser pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

   // default component width, two's complement
   localparam int COMPONENT_WIDTH_DEF = 16;
   // components per item
   localparam int NUM_COMP = 4;

endpackage : vn_pkg

`default_nettype wire

// ===== rtl/vn_front.sv =====
// ----------------------------------------------------------------------------
// vn_front
// Magnitude, squaring and search set-up: three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_front #(
   parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            in_valid,
   input  wire logic [vn_pkg::NUM_COMP-1:0][COMPONENT_WIDTH-1:0] in_comp,
   output logic                                                 out_valid,
   output logic [vn_pkg::NUM_COMP-1:0][4*COMPONENT_WIDTH+2:0]   out_e,
   output logic [vn_pkg::NUM_COMP-1:0][4*COMPONENT_WIDTH+2:0]   out_ms,
   output logic [2*COMPONENT_WIDTH:0]                           out_s,
   output logic [vn_pkg::NUM_COMP-1:0]                          out_neg,
   output logic                                                 out_zero
);
   import vn_pkg::*;

   localparam int CW   = COMPONENT_WIDTH;
   localparam int FRAC = CW - 2;
   localparam int SW   = 2 * CW + 1;
   localparam int EW   = 4 * CW + 3;

   // stage a: magnitude and sign
   logic                             va_ff, va_in;
   logic [NUM_COMP-1:0][CW-1:0]      mag_ff, mag_in;
   logic [NUM_COMP-1:0]              nega_ff, nega_in;
   // stage b: squares
   logic                             vb_ff;
   logic [NUM_COMP-1:0][2*CW-1:0]    sq_ff, sq_in;
   logic [NUM_COMP-1:0]              negb_ff;
   logic                             zerob_ff, zerob_in;
   // stage c: sum and initial residuals
   logic                             vc_ff;
   logic [NUM_COMP-1:0][EW-1:0]      e_ff, e_in;
   logic [NUM_COMP-1:0][EW-1:0]      ms_ff, ms_in;
   logic [SW-1:0]                    s_ff, s_in;
   logic [NUM_COMP-1:0]              negc_ff;
   logic                             zeroc_ff;
   logic [EW-1:0]                    s_ext;

   assign va_in = in_valid;

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         nega_in[i] = in_comp[i][CW-1];
         mag_in[i]  = nega_in[i] ? (~in_comp[i] + {{(CW-1){1'b0}}, 1'b1}) : in_comp[i];
      end
   end

   always_comb begin
      zerob_in = 1'b1;
      for (int i = 0; i < NUM_COMP; i++) begin
         sq_in[i] = mag_ff[i] * mag_ff[i];
         if (mag_ff[i] != '0) begin
            zerob_in = 1'b0;
         end
      end
   end

   always_comb begin
      s_in = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
         s_in = s_in + {1'b0, sq_ff[i]};
      end
      s_ext = {{(EW-SW){1'b0}}, s_in};
      for (int i = 0; i < NUM_COMP; i++) begin
         // residual for k = 0: 4 c^2 2^(2F) - S, and (2k-1) S = -S
         e_in[i]  = ({{(EW-2*CW){1'b0}}, sq_ff[i]} << (2*FRAC+2)) - s_ext;
         ms_in[i] = '0 - s_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      nega_ff  <= nega_in;
      sq_ff    <= sq_in;
      negb_ff  <= nega_ff;
      zerob_ff <= zerob_in;
      e_ff     <= e_in;
      ms_ff    <= ms_in;
      s_ff     <= s_in;
      negc_ff  <= negb_ff;
      zeroc_ff <= zerob_ff;
   end

   assign out_valid = vc_ff;
   assign out_e     = e_ff;
   assign out_ms    = ms_ff;
   assign out_s     = s_ff;
   assign out_neg   = negc_ff;
   assign out_zero  = zeroc_ff;

endmodule : vn_front

`default_nettype wire

// ===== rtl/vn_step.sv =====
// ----------------------------------------------------------------------------
// vn_step
// One bit of the rounded quotient search, all four lanes, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_step #(
   parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF,
   parameter int BIT_POS         = 0
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire logic                                             in_valid,
   input  wire logic [vn_pkg::NUM_COMP-1:0][4*COMPONENT_WIDTH+2:0] in_e,
   input  wire logic [vn_pkg::NUM_COMP-1:0][4*COMPONENT_WIDTH+2:0] in_ms,
   input  wire logic [2*COMPONENT_WIDTH:0]                       in_s,
   input  wire logic [vn_pkg::NUM_COMP-1:0][COMPONENT_WIDTH-2:0] in_q,
   input  wire logic [vn_pkg::NUM_COMP-1:0]                      in_neg,
   input  wire logic                                             in_zero,
   output logic                                                  out_valid,
   output logic [vn_pkg::NUM_COMP-1:0][4*COMPONENT_WIDTH+2:0]    out_e,
   output logic [vn_pkg::NUM_COMP-1:0][4*COMPONENT_WIDTH+2:0]    out_ms,
   output logic [2*COMPONENT_WIDTH:0]                            out_s,
   output logic [vn_pkg::NUM_COMP-1:0][COMPONENT_WIDTH-2:0]      out_q,
   output logic [vn_pkg::NUM_COMP-1:0]                           out_neg,
   output logic                                                  out_zero
);
   import vn_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int SW = 2 * CW + 1;
   localparam int EW = 4 * CW + 3;
   localparam int QW = CW - 1;

   logic                          v_ff;
   logic [NUM_COMP-1:0][EW-1:0]   e_ff, e_in;
   logic [NUM_COMP-1:0][EW-1:0]   ms_ff, ms_in;
   logic [SW-1:0]                 s_ff;
   logic [NUM_COMP-1:0][QW-1:0]   q_ff, q_in;
   logic [NUM_COMP-1:0]           neg_ff;
   logic                          zero_ff;
   logic [EW-1:0]                 s_ext;
   logic [EW-1:0]                 trial;

   // Setting bit d = 2^BIT_POS on k moves m = 2k-1 to m + 2d:
   // residual drops by 4 d m S + 4 d^2 S; keep the bit while it stays >= 0.
   always_comb begin
      s_ext = {{(EW-SW){1'b0}}, in_s};
      trial = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
         trial = in_e[i] - ((in_ms[i] << (BIT_POS+2)) + (s_ext << (2*BIT_POS+2)));
         if (!trial[EW-1]) begin
            e_in[i]  = trial;
            ms_in[i] = in_ms[i] + (s_ext << (BIT_POS+1));
            q_in[i]  = in_q[i] | (QW'(1) << BIT_POS);
         end else begin
            e_in[i]  = in_e[i];
            ms_in[i] = in_ms[i];
            q_in[i]  = in_q[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_ff    <= e_in;
      ms_ff   <= ms_in;
      s_ff    <= in_s;
      q_ff    <= q_in;
      neg_ff  <= in_neg;
      zero_ff <= in_zero;
   end

   assign out_valid = v_ff;
   assign out_e     = e_ff;
   assign out_ms    = ms_ff;
   assign out_s     = s_ff;
   assign out_q     = q_ff;
   assign out_neg   = neg_ff;
   assign out_zero  = zero_ff;

endmodule : vn_step

`default_nettype wire

// ===== rtl/vector4_normalize.sv =====
// ----------------------------------------------------------------------------
// vector4_normalize
// Scales a four-component fixed-point vector to unit length, exactly rounded.
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+---------------------------
//  request  | req_x, req_y, req_z, req_w          | start high, busy low
//  result   | rsp_x .. rsp_w, rsp_zero_length     | rsp_valid, one cycle each
//
//  One item enters every cycle; busy is never raised.
//  The pipeline is three set-up stages, one stage per quotient bit
//  (COMPONENT_WIDTH - 1 of them), and the output register. The
//  bit-per-stage search sets the pipeline depth.
//  Reset clears the valid bits only; items in flight are dropped.
//  The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
`default_nettype none

module vector4_normalize #(
   parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_w,
   output logic                                   rsp_valid,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_x,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_y,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_z,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_w,
   output logic                                   rsp_zero_length
);
   import vn_pkg::*;

   localparam int CW   = COMPONENT_WIDTH;
   localparam int FRAC = CW - 2;
   localparam int SW   = 2 * CW + 1;
   localparam int EW   = 4 * CW + 3;
   localparam int QW   = CW - 1;

   // search chain, index n feeds the stage deciding bit FRAC - n
   logic                          v_ch    [0:QW];
   logic [NUM_COMP-1:0][EW-1:0]   e_ch    [0:QW];
   logic [NUM_COMP-1:0][EW-1:0]   ms_ch   [0:QW];
   logic [SW-1:0]                 s_ch    [0:QW];
   logic [NUM_COMP-1:0][QW-1:0]   q_ch    [0:QW];
   logic [NUM_COMP-1:0]           neg_ch  [0:QW];
   logic                          zero_ch [0:QW];

   logic [NUM_COMP-1:0][CW-1:0]   comp_in;
   logic                          accept;

   logic                          rv_ff;
   logic [NUM_COMP-1:0][CW-1:0]   res_ff, res_in;
   logic                          zl_ff;

   // the pipeline takes an item every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign comp_in[0] = req_x;
   assign comp_in[1] = req_y;
   assign comp_in[2] = req_z;
   assign comp_in[3] = req_w;

   vn_front #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_comp   (comp_in),
      .out_valid (v_ch[0]),
      .out_e     (e_ch[0]),
      .out_ms    (ms_ch[0]),
      .out_s     (s_ch[0]),
      .out_neg   (neg_ch[0]),
      .out_zero  (zero_ch[0])
   );

   assign q_ch[0] = '0;

   // one stage per quotient bit, most significant first
   for (genvar n = 0; n < QW; n++) begin : g_step
      vn_step #(
         .COMPONENT_WIDTH (COMPONENT_WIDTH),
         .BIT_POS         (FRAC - n)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_ch[n]),
         .in_e      (e_ch[n]),
         .in_ms     (ms_ch[n]),
         .in_s      (s_ch[n]),
         .in_q      (q_ch[n]),
         .in_neg    (neg_ch[n]),
         .in_zero   (zero_ch[n]),
         .out_valid (v_ch[n+1]),
         .out_e     (e_ch[n+1]),
         .out_ms    (ms_ch[n+1]),
         .out_s     (s_ch[n+1]),
         .out_q     (q_ch[n+1]),
         .out_neg   (neg_ch[n+1]),
         .out_zero  (zero_ch[n+1])
      );
   end

   // clamp to 1.0, drop to zero for a null vector, restore the sign
   always_comb begin
      logic [CW-1:0] mag;
      for (int i = 0; i < NUM_COMP; i++) begin
         mag = {1'b0, q_ch[QW][i]};
         if (mag > (CW'(1) << FRAC)) begin
            mag = CW'(1) << FRAC;
         end
         if (zero_ch[QW]) begin
            mag = '0;
         end
         res_in[i] = neg_ch[QW][i] ? ('0 - mag) : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= v_ch[QW];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      zl_ff  <= zero_ch[QW];
   end

   assign rsp_valid       = rv_ff;
   assign rsp_x           = res_ff[0];
   assign rsp_y           = res_ff[1];
   assign rsp_z           = res_ff[2];
   assign rsp_w           = res_ff[3];
   assign rsp_zero_length = zl_ff;

endmodule : vector4_normalize

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vector4_normalize: drives vectors through the
// command port, predicts the exactly rounded unit vector for each accepted
// item and compares every strobed result in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class norm_scoreboard;
   localparam int W = vn_pkg::COMPONENT_WIDTH_DEF;
   localparam int FB = W - 2;

   typedef struct {
      logic signed [W-1:0] c [4];
      logic                zero_length;
   } unit_vec_t;

   unit_vec_t pending [$];
   int        fail_count;

   function new();
      fail_count = 0;
   endfunction

   // largest k with (2|c|2^F)^2 >= (2k-1)^2 * S, clamped to 1.0
   static function logic [W-1:0] scaled_mag(longint unsigned m, longint unsigned s);
      logic [127:0]    lhs;
      logic [127:0]    rhs;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned odd;
      lhs = 128'(m << (FB + 1)) * 128'(m << (FB + 1));
      lo  = 0;
      hi  = 64'd1 << FB;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         odd = 2 * mid - 1;
         rhs = 128'(odd) * 128'(odd) * 128'(s);
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      return W'(lo);
   endfunction

   // note an accepted item and queue the vector it should produce
   function void note_item(logic signed [W-1:0] v [4]);
      unit_vec_t       e;
      longint unsigned mag [4];
      longint unsigned sum;
      logic [W-1:0]    q;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = v[i] < 0 ? longint'(-longint'(v[i])) : longint'(v[i]);
         sum += mag[i] * mag[i];
      end
      e.zero_length = (sum == 0);
      for (int i = 0; i < 4; i++) begin
         q = (sum == 0 || mag[i] == 0) ? '0 : scaled_mag(mag[i], sum);
         e.c[i] = v[i] < 0 ? -q : q;
      end
      pending.push_back(e);
   endfunction

   function void check_result(logic signed [W-1:0] r [4], logic zl);
      unit_vec_t e;
      string     nm [4] = '{"rsp_x", "rsp_y", "rsp_z", "rsp_w"};
      if (pending.size() == 0) begin
         $error("unexpected result: no item outstanding");
         fail_count++;
         return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 4; i++)
         if (r[i] !== e.c[i]) begin
            $error("%s mismatch: expected %0d, got %0d", nm[i], e.c[i], r[i]);
            fail_count++;
         end
      if (zl !== e.zero_length) begin
         $error("rsp_zero_length mismatch: expected %0b, got %0b", e.zero_length, zl);
         fail_count++;
      end
   endfunction
endclass

module testbench;
   localparam int W = vn_pkg::COMPONENT_WIDTH_DEF;
   localparam int LATENCY = W + 3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic signed [W-1:0] req_x = '0, req_y = '0, req_z = '0, req_w = '0;
   logic                rsp_valid;
   logic signed [W-1:0] rsp_x, rsp_y, rsp_z, rsp_w;
   logic                rsp_zero_length;

   norm_scoreboard unit_board = new();
   int             idle_pct;   // percentage of cycles the sender holds off

   vector4_normalize dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x(req_x), .req_y(req_y), .req_z(req_z), .req_w(req_w),
      .rsp_valid(rsp_valid), .rsp_x(rsp_x), .rsp_y(rsp_y), .rsp_z(rsp_z),
      .rsp_w(rsp_w), .rsp_zero_length(rsp_zero_length)
   );

   always #4 clock = ~clock;

   // sample at the rising edge: note accepted items, check strobed results
   always @(posedge clock) begin
      logic signed [W-1:0] v [4];
      logic signed [W-1:0] r [4];
      if (!reset) begin
         if (start && !busy) begin
            v = '{req_x, req_y, req_z, req_w};
            unit_board.note_item(v);
         end
         if (rsp_valid) begin
            r = '{rsp_x, rsp_y, rsp_z, rsp_w};
            unit_board.check_result(r, rsp_zero_length);
         end
      end
   end

   // present one item at the falling edge and hold it until accepted;
   // start stays high across back-to-back items
   task automatic send_vector(logic signed [W-1:0] x, y, z, w);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_x <= x;
      req_y <= y;
      req_z <= z;
      req_w <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // random component: mostly full range, some small or extreme values
   function automatic logic signed [W-1:0] rand_comp();
      case ($urandom_range(9))
         0: return '0;
         1: return W'($urandom_range(7)) - W'(4);
         2: return $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         3: return $urandom_range(1) ? W'(16384) : -W'(16384);
         default: return W'($urandom());
      endcase
   endfunction

   initial begin
      logic signed [W-1:0] mn, mx;
      int                  phase_pct [4];
      phase_pct = '{0, 74, 0, 9};
      mn = {1'b1, {(W-1){1'b0}}};
      mx = {1'b0, {(W-1){1'b1}}};
      idle_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero vector, single axes, extremes, ties, tiny values
      send_vector(0, 0, 0, 0);
      send_vector(1, 0, 0, 0);
      send_vector(0, -1, 0, 0);
      send_vector(0, 0, mx, 0);
      send_vector(0, 0, 0, mn);
      send_vector(mn, mn, mn, mn);
      send_vector(mx, mx, mx, mx);
      send_vector(mn, mx, mn, mx);
      send_vector(16384, 16384, 16384, 16384);
      send_vector(3, 4, 0, 0);
      send_vector(-3, 0, -4, 0);
      send_vector(1, 1, 1, 1);
      send_vector(-1, 1, -1, 1);
      send_vector(mx, 1, 0, -1);
      send_vector(mn, 0, 0, 1);
      send_vector(12, -5, 0, 0);
      send_vector(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00);
      send_vector(0, 0, 0, 0);

      // random, in four idling phases
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         repeat (185) send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      start <= 1'b0;

      // drain, then allow the pipeline depth again
      while (unit_board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (unit_board.fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== vector4_normalize.f =====
rtl/vn_pkg.sv
rtl/vn_front.sv
rtl/vn_step.sv
rtl/vector4_normalize.sv
verif/testbench.sv
